// ----- design/gni_pkg.sv -----
// shared types, constants and helpers of the gaussian noise injector
package gni_pkg;

    localparam int unsigned LAG_W  = 30;
    localparam int unsigned LAG_AW = 6;

    typedef logic [LAG_W-1:0]  t_lag;
    typedef logic [LAG_AW-1:0] t_lag_addr;

    localparam t_lag MOD_BIG    = 30'd1000000000;
    localparam t_lag SEED_MAGIC = 30'd161803398;

    localparam t_lag_addr LAG_LAST    = 6'd54;
    localparam t_lag_addr LAG_TOP     = 6'd55;
    localparam t_lag_addr FILL_STRIDE = 6'd21;
    localparam t_lag_addr TRAIL_START = 6'd31;
    localparam t_lag_addr MIX_TAP     = 6'd31;

    localparam logic [30:0] TWO_LN2_Q30  = 31'd1488522236;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [30:0] SIGMA_RESET  = 31'd65536;

    // floor(2^62 / 10^9), reciprocal for scaling a draw to q0.32
    localparam logic [32:0] RCP_1E9_Q62  = 33'd4611686018;

    // configuration register indexes
    localparam logic [1:0] CFG_MEAN  = 2'd0;
    localparam logic [1:0] CFG_SIGMA = 2'd1;
    localparam logic [1:0] CFG_SEED  = 2'd2;

    typedef struct packed {
        t_lag r1;
        t_lag r2;
        logic use_sine;
    } t_draw;

    // a - b modulo 10^9, both inputs below 10^9
    function automatic t_lag sub_mod(input t_lag a, input t_lag b);
        logic [LAG_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[LAG_W]) begin
            d = d + {1'b0, MOD_BIG};
        end
        return d[LAG_W-1:0];
    endfunction

    // quarter-wave sine, q16
    function automatic logic [16:0] quarter_sine(input logic [4:0] i);
        logic [16:0] s;
        case (i)
            5'd0:    s = 17'd0;
            5'd1:    s = 17'd6424;
            5'd2:    s = 17'd12785;
            5'd3:    s = 17'd19024;
            5'd4:    s = 17'd25080;
            5'd5:    s = 17'd30893;
            5'd6:    s = 17'd36410;
            5'd7:    s = 17'd41576;
            5'd8:    s = 17'd46341;
            5'd9:    s = 17'd50660;
            5'd10:   s = 17'd54491;
            5'd11:   s = 17'd57798;
            5'd12:   s = 17'd60547;
            5'd13:   s = 17'd62714;
            5'd14:   s = 17'd64277;
            5'd15:   s = 17'd65220;
            5'd16:   s = 17'd65536;
            default: s = 17'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- design/gaussian_noise_injector_unit.sv -----
// top level of the gaussian noise injector
// Adds gaussian noise to each signed q16.16 sample: out = sat(in + mean + sigma * nd), where
// nd is a box-muller deviate built from two uniforms of a 55-entry subtractive generator,
// taking the cosine and sine forms on alternate beats. The front end takes one input beat at
// a time: the accept state, then two read-modify-writes of the lag table, each a read state
// and a write state on its single write port. The back end sets the sustained rate and works
// on one sample at a time: two reciprocal scalings by 10^9, a normalize, repeated squaring
// for the log, a square root, then multiply and add; a finished result waits until the
// output register has room. A two-entry queue parts the two ends and an output register
// parts the back end from the consumer. After reset and after each seed write the generator
// runs a seeding pass (table fill, mixing passes and WARMUP_ITEMS discarded warm-up draws)
// during which full stays high; mean and sigma writes take effect at once.
module gaussian_noise_injector_unit #(
    parameter int WARMUP_ITEMS = 100,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input queue side
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    // result queue side
    output logic                   empty,
    input  logic                   pop,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import gni_pkg::*;

    localparam int DRAW_W = $bits(t_draw);
    localparam int QW     = SAMPLE_BITS + DRAW_W;

    // configuration registers, seed lives in the generator
    logic signed [31:0] r_mean, n_mean;
    logic [30:0]        r_sigma, n_sigma;
    logic               seed_we;

    // front end to queue
    logic                   fq_push;
    logic [SAMPLE_BITS-1:0] fq_sample;
    t_draw                  fq_draw;
    logic                   fq_room;

    // queue to back end
    logic          qb_valid, qb_take;
    logic [QW-1:0] qb_data;
    t_draw         qb_draw;

    // back end to output register
    logic                   bo_push;
    logic [SAMPLE_BITS-1:0] bo_sample;
    logic                   out_room;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data, n_out_data;

    always_comb begin
        n_mean  = r_mean;
        n_sigma = r_sigma;
        seed_we = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MEAN:  n_mean  = i_cfg_data;
                CFG_SIGMA: n_sigma = i_cfg_data[30:0];
                CFG_SEED:  seed_we = 1'b1;
                default:   ; // unused index, write dropped
            endcase
        end
    end

    gni_rng #(
        .WARMUP_ITEMS (WARMUP_ITEMS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_rng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed_we  (seed_we),
        .i_seed     (i_cfg_data[LAG_W-1:0]),
        .i_push     (push),
        .o_full     (full),
        .i_sample   (i_sample_in),
        .i_q_room   (fq_room),
        .o_q_push   (fq_push),
        .o_q_sample (fq_sample),
        .o_q_draw   (fq_draw)
    );

    // each entry holds one sample beat and its two uniforms
    gni_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  ({fq_sample, fq_draw}),
        .o_room  (fq_room),
        .i_pop   (qb_take),
        .o_valid (qb_valid),
        .o_data  (qb_data)
    );

    assign qb_draw = qb_data[DRAW_W-1:0];

    gni_noise #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_noise (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (qb_valid),
        .i_sample     (qb_data[QW-1:DRAW_W]),
        .i_draw       (qb_draw),
        .o_take       (qb_take),
        .i_mean       (r_mean),
        .i_sigma      (r_sigma),
        .i_out_room   (out_room),
        .o_out_push   (bo_push),
        .o_out_sample (bo_sample)
    );

    // output register takes a new result in the cycle the old one is popped
    assign out_room = !r_out_valid || pop;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (bo_push) begin
            n_out_valid = 1'b1;
            n_out_data  = bo_sample;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean      <= '0;
            r_sigma     <= SIGMA_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_mean      <= n_mean;
            r_sigma     <= n_sigma;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign empty        = !r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

// ----- design/gni_rng.sv -----
// front end: lag table generator, seeding sequencer and input beat intake
module gni_rng #(
    parameter int WARMUP_ITEMS = 100,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_seed_we,
    input  gni_pkg::t_lag          i_seed,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_q_room,
    output logic                   o_q_push,
    output logic [SAMPLE_BITS-1:0] o_q_sample,
    output gni_pkg::t_draw         o_q_draw
);
    import gni_pkg::*;

    localparam int WCW = $clog2(WARMUP_ITEMS + 2);

    typedef enum logic [6:0] {
        R_INIT   = 7'b0000001,
        R_FILL   = 7'b0000010,
        R_MIX_RD = 7'b0000100,
        R_MIX_WR = 7'b0001000,
        R_GEN_RD = 7'b0010000,
        R_GEN_WR = 7'b0100000,
        R_IDLE   = 7'b1000000
    } t_rstate;

    t_rstate r_state, n_state;
    t_lag    r_seed, n_seed;
    t_lag    r_mj, n_mj;
    t_lag    r_mk, n_mk;
    t_lag    r_r1, n_r1;
    t_lag_addr r_ii, n_ii;
    t_lag_addr r_cnt, n_cnt;
    t_lag_addr r_lead, n_lead;
    t_lag_addr r_trail, n_trail;
    logic [1:0] r_pass, n_pass;
    logic    r_step, n_step;
    logic    r_use_sine, n_use_sine;
    logic [WCW-1:0] r_warm, n_warm;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;

    t_lag r_mem [0:LAG_LAST];
    t_lag r_rd_a, r_rd_b;

    logic      w_we;
    t_lag_addr w_wa, w_ra, w_rb;
    t_lag      w_wd;
    t_lag      mj_init, v;
    t_lag_addr nl, nt, partner, ii_step;
    logic [LAG_AW:0] ii_sum, tap_sum;
    logic      q_push;

    function automatic t_lag_addr wrap_next(input t_lag_addr i);
        return (i >= LAG_TOP) ? t_lag_addr'(1) : i + t_lag_addr'(1);
    endfunction

    always_comb begin
        mj_init = (r_seed > SEED_MAGIC) ? r_seed - SEED_MAGIC : SEED_MAGIC - r_seed;
        v       = sub_mod(r_rd_a, r_rd_b);
        nl      = wrap_next(r_lead);
        nt      = wrap_next(r_trail);
        ii_sum  = {1'b0, r_ii} + {1'b0, FILL_STRIDE};
        ii_step = (ii_sum >= {1'b0, LAG_TOP}) ? LAG_AW'(ii_sum - {1'b0, LAG_TOP})
                                              : ii_sum[LAG_AW-1:0];
        tap_sum = {1'b0, r_cnt} + {1'b0, MIX_TAP};
        partner = (tap_sum >= {1'b0, LAG_TOP}) ? LAG_AW'(tap_sum - {1'b0, LAG_TOP})
                                               : tap_sum[LAG_AW-1:0];

        n_state    = r_state;
        n_seed     = r_seed;
        n_mj       = r_mj;
        n_mk       = r_mk;
        n_r1       = r_r1;
        n_ii       = r_ii;
        n_cnt      = r_cnt;
        n_lead     = r_lead;
        n_trail    = r_trail;
        n_pass     = r_pass;
        n_step     = r_step;
        n_use_sine = r_use_sine;
        n_warm     = r_warm;
        n_sample   = r_sample;
        w_we       = 1'b0;
        w_wa       = r_cnt;
        w_wd       = v;
        w_ra       = r_cnt;
        w_rb       = partner;
        q_push     = 1'b0;

        case (r_state)
            R_INIT: begin
                w_we    = 1'b1;
                w_wa    = LAG_LAST;
                w_wd    = mj_init;
                n_mj    = mj_init;
                n_mk    = t_lag'(1);
                n_ii    = FILL_STRIDE;
                n_cnt   = t_lag_addr'(1);
                n_state = R_FILL;
            end
            R_FILL: begin
                w_we  = 1'b1;
                w_wa  = r_ii - t_lag_addr'(1);
                w_wd  = r_mk;
                n_mk  = sub_mod(r_mj, r_mk);
                n_mj  = r_mk;
                n_ii  = ii_step;
                n_cnt = r_cnt + t_lag_addr'(1);
                if (r_cnt == LAG_LAST) begin
                    n_cnt   = '0;
                    n_pass  = '0;
                    n_state = R_MIX_RD;
                end
            end
            R_MIX_RD: begin
                n_state = R_MIX_WR;
            end
            R_MIX_WR: begin
                w_we = 1'b1;
                if (r_cnt == LAG_LAST) begin
                    n_cnt = '0;
                    if (r_pass == 2'd3) begin
                        n_lead  = '0;
                        n_trail = TRAIL_START;
                        n_step  = 1'b0;
                        n_warm  = WCW'(WARMUP_ITEMS);
                        n_state = (WARMUP_ITEMS == 0) ? R_IDLE : R_GEN_RD;
                    end else begin
                        n_pass  = r_pass + 2'd1;
                        n_state = R_MIX_RD;
                    end
                end else begin
                    n_cnt   = r_cnt + t_lag_addr'(1);
                    n_state = R_MIX_RD;
                end
            end
            R_GEN_RD: begin
                n_lead  = nl;
                n_trail = nt;
                w_ra    = nl - t_lag_addr'(1);
                w_rb    = nt - t_lag_addr'(1);
                n_state = R_GEN_WR;
            end
            R_GEN_WR: begin
                w_we = 1'b1;
                w_wa = r_lead - t_lag_addr'(1);
                if (!r_step) begin
                    n_r1    = v;
                    n_step  = 1'b1;
                    n_state = R_GEN_RD;
                end else begin
                    n_step     = 1'b0;
                    n_use_sine = ~r_use_sine;
                    if (r_warm != '0) begin
                        n_warm  = r_warm - WCW'(1);
                        n_state = (r_warm == WCW'(1)) ? R_IDLE : R_GEN_RD;
                    end else begin
                        q_push  = 1'b1;
                        n_state = R_IDLE;
                    end
                end
            end
            R_IDLE: begin
                if (i_push && i_q_room) begin
                    n_sample = i_sample;
                    n_state  = R_GEN_RD;
                end
            end
            default: begin
                n_state = R_INIT;
            end
        endcase

        // seed write restarts seeding
        if (i_seed_we) begin
            n_seed     = i_seed;
            n_use_sine = 1'b0;
            n_state    = R_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= R_INIT;
            r_seed     <= '0;
            r_use_sine <= 1'b0;
            r_step     <= 1'b0;
            r_warm     <= '0;
        end else begin
            r_state    <= n_state;
            r_seed     <= n_seed;
            r_use_sine <= n_use_sine;
            r_step     <= n_step;
            r_warm     <= n_warm;
        end
        r_mj     <= n_mj;
        r_mk     <= n_mk;
        r_r1     <= n_r1;
        r_ii     <= n_ii;
        r_cnt    <= n_cnt;
        r_lead   <= n_lead;
        r_trail  <= n_trail;
        r_pass   <= n_pass;
        r_sample <= n_sample;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_rb];
    end

    assign o_full     = !((r_state == R_IDLE) && i_q_room);
    assign o_q_push   = q_push;
    assign o_q_sample = r_sample;
    assign o_q_draw   = '{r1: r_r1, r2: v, use_sine: r_use_sine};

endmodule

// ----- design/gni_fifo.sv -----
// two-entry queue between front end and back end
module gni_fifo #(
    parameter int WIDTH = 93
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_room,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [0:1];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    always_comb begin
        do_push = i_push && (r_count != 2'd2);
        do_pop  = i_pop && (r_count != 2'd0);
        n_wp    = do_push ? ~r_wp : r_wp;
        n_rp    = do_pop ? ~r_rp : r_rp;
        n_count = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_room  = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

// ----- design/gni_noise.sv -----
// back end: box-muller deviate, scaling, offset and saturation
module gni_noise #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  gni_pkg::t_draw                i_draw,
    output logic                          o_take,
    input  logic signed [31:0]            i_mean,
    input  logic [30:0]                   i_sigma,
    input  logic                          i_out_room,
    output logic                          o_out_push,
    output logic [SAMPLE_BITS-1:0]        o_out_sample
);
    import gni_pkg::*;

    localparam int SUM_W = ((SAMPLE_BITS > 36) ? SAMPLE_BITS : 36) + 3;
    localparam int SQ_W  = 40;
    localparam logic [SQ_W-1:0] SQ_BIT_TOP = SQ_W'(1) << 38;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [10:0] {
        B_IDLE  = 11'b00000000001,
        B_DIV   = 11'b00000000010,
        B_FIX   = 11'b00000000100,
        B_NORM  = 11'b00000001000,
        B_SQ    = 11'b00000010000,
        B_LOG   = 11'b00000100000,
        B_SQRT  = 11'b00001000000,
        B_TRIG  = 11'b00010000000,
        B_ND    = 11'b00100000000,
        B_SCALE = 11'b01000000000,
        B_SUM   = 11'b10000000000
    } t_bstate;

    t_bstate r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    t_draw       r_draw, n_draw;
    logic        r_sel, n_sel;
    t_lag        r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic [4:0]  r_p, n_p;
    logic [30:0] r_m, n_m;
    logic [15:0] r_f, n_f;
    logic [SQ_W-1:0] r_v, n_v;
    logic [SQ_W-1:0] r_r, n_r;
    logic [SQ_W-1:0] r_b, n_b;
    logic [19:0] r_amp, n_amp;
    logic [16:0] r_tmag, n_tmag;
    logic        r_neg, n_neg;
    logic [20:0] r_nd, n_nd;
    logic [35:0] r_sc, n_sc;

    logic [61:0]     rcp_prod;
    logic [31:0]     fix_lo, fix_rem;
    logic            fix_up;
    logic [61:0]     sq_prod;
    logic [31:0]     sq_s;
    logic [21:0]     log_a;
    logic [52:0]     log_prod;
    logic [SQ_W-1:0] sq_sum, sq_r_next;
    logic            sq_take;
    logic [31:0]     ph;
    logic [30:0]     pp;
    logic [4:0]      idx;
    logic [15:0]     frac;
    logic [16:0]     base, nxt, diff;
    logic [32:0]     interp;
    logic [36:0]     nd_prod;
    logic [51:0]     sc_prod;
    logic signed [SUM_W-1:0] sc_s, sum_full, sum_sat;
    logic            take, out_push;

    always_comb begin
        // x * 2^32 / 10^9 by reciprocal, the estimate is exact or one low
        rcp_prod = {32'b0, r_rem} * {29'b0, RCP_1E9_Q62};
        // remainder of the estimate fits in 32 bits, low bits of x * 2^32 are zero
        fix_lo   = r_quo * {2'b0, MOD_BIG};
        fix_rem  = 32'd0 - fix_lo;
        fix_up   = (fix_rem >= {2'b0, MOD_BIG});

        // log2 fraction by repeated squaring of the q1.30 mantissa
        sq_prod = {31'b0, r_m} * {31'b0, r_m};
        sq_s    = sq_prod[61:30];

        log_a    = {6'd32 - {1'b0, r_p}, 16'b0} - {6'b0, r_f};
        log_prod = {31'b0, log_a} * {22'b0, TWO_LN2_Q30};

        sq_sum    = r_r + r_b;
        sq_take   = (r_v >= sq_sum);
        sq_r_next = sq_take ? (r_r >> 1) + r_b : (r_r >> 1);

        // phase in turns, cosine is sine a quarter turn ahead
        ph     = r_quo + (r_draw.use_sine ? 32'd0 : QUARTER_TURN);
        pp     = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
        idx    = pp[30:26];
        frac   = pp[25:10];
        base   = quarter_sine(idx);
        nxt    = quarter_sine(idx + 5'd1);
        diff   = nxt - base;
        interp = {16'b0, diff} * {17'b0, frac};

        nd_prod = {17'b0, r_amp} * {20'b0, r_tmag};
        sc_prod = {21'b0, i_sigma} * {31'b0, r_nd};

        sc_s     = SUM_W'(r_sc);
        sum_full = SUM_W'(r_sample) + SUM_W'(i_mean) + (r_neg ? -sc_s : sc_s);
        if (sum_full > SAT_HI) begin
            sum_sat = SAT_HI;
        end else if (sum_full < SAT_LO) begin
            sum_sat = SAT_LO;
        end else begin
            sum_sat = sum_full;
        end

        n_state  = r_state;
        n_sample = r_sample;
        n_draw   = r_draw;
        n_sel    = r_sel;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_p      = r_p;
        n_m      = r_m;
        n_f      = r_f;
        n_v      = r_v;
        n_r      = r_r;
        n_b      = r_b;
        n_amp    = r_amp;
        n_tmag   = r_tmag;
        n_neg    = r_neg;
        n_nd     = r_nd;
        n_sc     = r_sc;
        take     = 1'b0;
        out_push = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    take     = 1'b1;
                    n_sample = i_sample;
                    n_draw   = i_draw;
                    // zero uniform is taken as the smallest step
                    n_rem    = (i_draw.r1 == '0) ? t_lag'(1) : i_draw.r1;
                    n_quo    = '0;
                    n_cnt    = '0;
                    n_sel    = 1'b0;
                    n_state  = B_DIV;
                end
            end
            B_DIV: begin
                n_quo   = rcp_prod[61:30];
                n_state = B_FIX;
            end
            B_FIX: begin
                n_quo   = r_quo + {31'b0, fix_up};
                n_p     = 5'd31;
                n_state = r_sel ? B_TRIG : B_NORM;
            end
            B_NORM: begin
                if (r_quo[31]) begin
                    n_m     = r_quo[31:1];
                    n_f     = '0;
                    n_cnt   = '0;
                    n_state = B_SQ;
                end else begin
                    n_quo = {r_quo[30:0], 1'b0};
                    n_p   = r_p - 5'd1;
                end
            end
            B_SQ: begin
                n_m   = sq_s[31] ? sq_s[31:1] : sq_s[30:0];
                n_f   = {r_f[14:0], sq_s[31]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_state = B_LOG;
                end
            end
            B_LOG: begin
                n_v     = SQ_W'({log_prod[52:30], 16'b0});
                n_r     = '0;
                n_b     = SQ_BIT_TOP;
                n_state = B_SQRT;
            end
            B_SQRT: begin
                if (sq_take) begin
                    n_v = r_v - sq_sum;
                end
                n_r = sq_r_next;
                n_b = r_b >> 2;
                if (r_b[0]) begin
                    n_amp   = sq_r_next[19:0];
                    n_rem   = r_draw.r2;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_sel   = 1'b1;
                    n_state = B_DIV;
                end
            end
            B_TRIG: begin
                n_tmag  = idx[4] ? 17'd65536 : base + interp[32:16];
                n_neg   = ph[31];
                n_state = B_ND;
            end
            B_ND: begin
                n_nd    = nd_prod[36:16];
                n_state = B_SCALE;
            end
            B_SCALE: begin
                n_sc    = sc_prod[51:16];
                n_state = B_SUM;
            end
            B_SUM: begin
                if (i_out_room) begin
                    out_push = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sample <= n_sample;
        r_draw   <= n_draw;
        r_sel    <= n_sel;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_p      <= n_p;
        r_m      <= n_m;
        r_f      <= n_f;
        r_v      <= n_v;
        r_r      <= n_r;
        r_b      <= n_b;
        r_amp    <= n_amp;
        r_tmag   <= n_tmag;
        r_neg    <= n_neg;
        r_nd     <= n_nd;
        r_sc     <= n_sc;
    end

    assign o_take       = take;
    assign o_out_push   = out_push;
    assign o_out_sample = SAMPLE_BITS'(sum_sat);

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the gaussian noise injector unit
`timescale 1ns / 100ps

module tb;
    import gni_pkg::*;

    // index with no register behind it, a write there must be ignored
    localparam logic [1:0] CFG_NONE = 2'd3;
    localparam longint     MOD_1E9  = 1000000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_sample_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_sample_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MEAN;
    logic [31:0] i_cfg_data = '0;

    gaussian_noise_injector_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample_in (i_sample_in),
        .empty       (empty),
        .pop         (pop),
        .o_sample_out(o_sample_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // own copy of the generator and the settings
    longint          lag_mem [55];
    int              lead_pos;
    int              trail_pos;
    bit              sine_turn;
    longint          cur_mean;
    longint unsigned cur_sigma;

    logic [31:0] pending_samples [$];
    logic [31:0] noisy_due [$];

    bit          took_in;
    bit          took_out;
    bit          no_gaps;
    int          send_gap;
    int          pop_stall;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned bad_beats;
    int unsigned seed_writes;

    // quarter-wave sine in q16
    longint qtab [17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
                          50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};

    function automatic longint lag_advance();
        longint v;
        lead_pos  = (lead_pos >= 55) ? 1 : lead_pos + 1;
        trail_pos = (trail_pos >= 55) ? 1 : trail_pos + 1;
        v = lag_mem[lead_pos-1] - lag_mem[trail_pos-1];
        if (v < 0) v += MOD_1E9;
        lag_mem[lead_pos-1] = v;
        return v;
    endfunction

    // table fill from the seed, four mixing passes, then the discarded warm-up draws
    task automatic seed_generator(input longint unsigned seed_val);
        longint mj;
        longint mk;
        longint d;
        longint dummy;
        int     ii;
        d  = longint'(SEED_MAGIC) - longint'(seed_val);
        mj = (d < 0 ? -d : d) % MOD_1E9;
        lag_mem[54] = mj;
        mk = 1;
        for (int i = 1; i <= 54; i++) begin
            ii = (21 * i) % 55;
            lag_mem[ii-1] = mk;
            mk = mj - mk;
            if (mk < 0) mk += MOD_1E9;
            mj = lag_mem[ii-1];
        end
        for (int k = 0; k < 4; k++) begin
            for (int i = 1; i <= 55; i++) begin
                lag_mem[i-1] -= lag_mem[(i + 30) % 55];
                if (lag_mem[i-1] < 0) lag_mem[i-1] += MOD_1E9;
            end
        end
        lead_pos  = 0;
        trail_pos = 31;
        sine_turn = 1'b0;
        for (int i = 0; i < 100; i++) begin
            dummy = lag_advance();
            dummy = lag_advance();
            sine_turn ^= 1'b1;
        end
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint quarter_wave(input logic [31:0] p);
        longint unsigned idx;
        longint unsigned frac;
        idx = p >> 26;
        if (idx >= 16) return qtab[16];
        frac = (p >> 10) & 32'hFFFF;
        return qtab[idx] + longint'(((qtab[idx+1] - qtab[idx]) * frac) >> 16);
    endfunction

    function automatic longint sine_of_turns(input logic [31:0] ph);
        logic [31:0] p;
        p = {2'b00, ph[29:0]};
        case (ph[31:30])
            2'd0:    return quarter_wave(p);
            2'd1:    return quarter_wave(QUARTER_TURN - p);
            2'd2:    return -quarter_wave(p);
            default: return -quarter_wave(QUARTER_TURN - p);
        endcase
    endfunction

    // box-muller deviate in q4.16, consumes two draws and flips the cos/sin turn
    function automatic longint gauss_deviate();
        longint          r1;
        longint          r2;
        longint unsigned x;
        longint unsigned m;
        longint unsigned a;
        longint unsigned amp;
        longint unsigned mag;
        longint unsigned f;
        int              p;
        logic [31:0]     ph;
        longint          trig;
        r1 = lag_advance();
        r2 = lag_advance();
        if (r1 == 0) r1 = 1;
        x = (longint'(r1) << 32) / MOD_1E9;
        p = 0;
        f = 0;
        for (int i = 0; i < 32; i++) if (x[i]) p = i;
        m = (x << 30) >> p;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            f <<= 1;
            if (m >= (64'd1 << 31)) begin
                f |= 1;
                m >>= 1;
            end
        end
        a   = ((longint'(32 - p)) << 16) - f;
        a   = (a * longint'(TWO_LN2_Q30)) >> 30;
        amp = int_sqrt(a << 16);
        ph  = 32'((longint'(r2) << 32) / MOD_1E9);
        trig = sine_turn ? sine_of_turns(ph) : sine_of_turns(ph + QUARTER_TURN);
        sine_turn ^= 1'b1;
        mag = (amp * longint'(trig < 0 ? -trig : trig)) >> 16;
        return trig < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [31:0] noisy_sample(input logic [31:0] smp);
        longint          nd;
        longint unsigned mag;
        longint          sum;
        nd  = gauss_deviate();
        mag = (cur_sigma * longint'(nd < 0 ? -nd : nd)) >> 16;
        sum = longint'($signed(smp)) + cur_mean + (nd < 0 ? -longint'(mag) : longint'(mag));
        if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
        if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
        return sum[31:0];
    endfunction

    // register write at the falling edge, predictor follows at once since the block is idle
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_MEAN:  cur_mean = longint'($signed(val));
            CFG_SIGMA: cur_sigma = val[30:0];
            CFG_SEED: begin
                seed_writes++;
                seed_generator(val[29:0]);
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && noisy_due.size() == 0 && !push);
        repeat (20) @(negedge i_clk);
    endtask

    // input side: one push assignment per falling edge, random gap between beats
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !took_in) begin
            // beat still waiting on full
        end else if (send_gap > 0) begin
            push <= 1'b0;
            send_gap--;
        end else if (pending_samples.size() != 0) begin
            push        <= 1'b1;
            i_sample_in <= pending_samples.pop_front();
            send_gap    = no_gaps ? 0 : $urandom_range(0, 9);
        end else begin
            push <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop && took_out) begin
            pop_stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (pop_stall == 0) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                pop_stall--;
            end
        end else if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else begin
            pop <= 1'b1;
        end
    end

    // sample handshakes at the rising edge, predict on input, compare on output
    always @(posedge i_clk) begin
        took_in  = i_rst_n && push && !full;
        took_out = i_rst_n && pop && !empty;
        if (took_in) begin
            noisy_due.push_back(noisy_sample(i_sample_in));
            beats_in++;
        end
        if (took_out) begin
            beats_out++;
            if (noisy_due.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected result beat %h at %0t", o_sample_out, $realtime);
            end else begin
                if (o_sample_out !== noisy_due[0]) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("sample_out beat %0d: expected %h, got %h", beats_out,
                                 noisy_due[0], o_sample_out);
                end
                void'(noisy_due.pop_front());
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", noisy_due.size());
        $display("gaussian_noise_injector_unit: mismatch");
        $finish;
    end

    initial begin
        logic [31:0] mean_v;
        logic [31:0] sigma_v;
        int          n;
        cur_mean  = 0;
        cur_sigma = SIGMA_RESET;
        seed_generator(0);
        no_gaps   = 1'b0;
        send_gap  = 0;
        pop_stall = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset: field extremes and walking values
        foreach (qtab[i]) begin end
        pending_samples = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1,
                            32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h0, 32'h0, 32'h0};
        drain();

        // saturation high with no noise, then low with the largest sigma
        cfg_write(CFG_MEAN, 32'h7FFF_FFFF);
        cfg_write(CFG_SIGMA, 32'h0);
        pending_samples = '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h1234_5678};
        drain();
        cfg_write(CFG_MEAN, 32'h8000_0000);
        cfg_write(CFG_SIGMA, 32'hFFFF_FFFF);
        pending_samples = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        drain();

        // ignored index, then a seed above the modulus and a zero seed
        cfg_write(CFG_NONE, 32'hFFFF_FFFF);
        cfg_write(CFG_MEAN, 32'h0);
        cfg_write(CFG_SIGMA, 32'h0001_0000);
        cfg_write(CFG_SEED, 32'hFFFF_FFFF);
        pending_samples = '{32'h0, 32'h0, 32'h0};
        drain();
        cfg_write(CFG_SEED, 32'h0);
        pending_samples = '{32'h0, 32'h0};
        drain();

        // random phases, each with its own settings
        for (int ph = 0; ph < 6; ph++) begin
            no_gaps = (ph % 3 == 1);
            case ($urandom_range(0, 3))
                0:       mean_v = $urandom;
                1:       mean_v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: mean_v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            endcase
            case ($urandom_range(0, 3))
                0:       sigma_v = $urandom;
                1:       sigma_v = 32'h0;
                default: sigma_v = $urandom_range(0, 32'h0010_0000);
            endcase
            cfg_write(CFG_MEAN, mean_v);
            cfg_write(CFG_SIGMA, sigma_v);
            if (ph != 2) cfg_write(CFG_SEED, $urandom_range(0, 999999999));
            n = 120;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0)
                    pending_samples.push_back($urandom);
                else
                    pending_samples.push_back($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
            end
            drain();
        end

        repeat (200) @(negedge i_clk);
        $display("%0d samples in, %0d out, %0d seed writes, 3 registers over 9 settings",
                 beats_in, beats_out, seed_writes);
        $display("saturation at both rails, ignored index write and random gaps on both sides");
        if (bad_beats == 0 && noisy_due.size() == 0) begin
            $display("gaussian_noise_injector_unit: match");
        end else begin
            $display("%0d bad beats, %0d results missing", bad_beats, noisy_due.size());
            $display("gaussian_noise_injector_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- gaussian_noise_injector_unit.f -----
design/gni_pkg.sv
design/gni_rng.sv
design/gni_fifo.sv
design/gni_noise.sv
design/gaussian_noise_injector_unit.sv
tb/tb.sv
